/* hdl/first_fit_extent_allocator_core_macros.svh */
// assertion macros of the allocator core rtl
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH

// clocked check, switched off while reset is held
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds through reset
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/ffa_pkg.sv */
// shared types and constants of the first-fit extent allocator
package ffa_pkg;

  // parameter defaults
  localparam int unsigned BLOCKS_DEF  = 256;
  localparam int unsigned FILES_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;

  // request and result field widths
  localparam int unsigned FILE_ID_W = 16;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned START_W   = 8;

  // request kinds
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_NOROOM   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // write control towards the occupancy bitmap
  typedef struct packed {
    logic wr_en;
    logic wr_bit;
  } bm_cmd_t;

endpackage

/* hdl/ffa_bitmap.sv */
// block occupancy bitmap, one bit per block, registered read
module ffa_bitmap #(
  parameter int unsigned BLOCKS = ffa_pkg::BLOCKS_DEF
) (
  input  logic                      clk_i,
  input  ffa_pkg::bm_cmd_t          cmd_i,
  input  logic [$clog2(BLOCKS)-1:0] addr_i,
  output logic                      rd_o
);

  logic mem [BLOCKS];
  logic rd_q;

  // single port: one address per cycle, written and read together (the read returns the old bit)
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr_i] <= cmd_i.wr_bit;
    end
    rd_q <= mem[addr_i];
  end

  assign rd_o = rd_q;

endmodule

/* hdl/first_fit_extent_allocator_core.sv */
// top level of the first-fit contiguous extent allocator
//
// Allocates and releases contiguous extents of a store of BLOCKS blocks for
// up to FILES files. A request (tuser: 0 allocate, 1 release) carries a file
// id and a block count; allocate places the file at the start of the lowest
// free run long enough, release frees the file's extent. One result per
// request. Requests are handled one at a time by a sequencer around a
// single compare unit: the file table is walked entry by entry (registered
// table read, then compare), the bitmap is scanned at one block per cycle
// through its single port, and the extent is then written back one block
// per cycle. The response step waits while the previous result has not
// been taken. After reset the bitmap is cleared one block per cycle, with
// tready low meanwhile.
module first_fit_extent_allocator_core #(
  parameter int unsigned BLOCKS  = ffa_pkg::BLOCKS_DEF,
  parameter int unsigned FILES   = ffa_pkg::FILES_DEF,
  parameter int unsigned ID_BITS = ffa_pkg::ID_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // file_id [15:0], block_count [24:16], zero
  input  logic        s_axis_tuser,  // command
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status [2:0], start_block [10:3], length [19:11], zero
);

  `include "first_fit_extent_allocator_core_macros.svh"

  localparam int unsigned BA_W  = $clog2(BLOCKS);
  localparam int unsigned CNT_W = $clog2(BLOCKS + 1);
  localparam int unsigned CMP_W = (CNT_W > ffa_pkg::COUNT_W) ? CNT_W : ffa_pkg::COUNT_W;
  localparam int unsigned TI_W  = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int unsigned ID_W  = (ID_BITS < ffa_pkg::FILE_ID_W) ? ID_BITS
                                                                 : ffa_pkg::FILE_ID_W;
  localparam int unsigned LEN_W = ffa_pkg::COUNT_W;
  localparam int unsigned ENT_W = ID_W + BA_W + LEN_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_TRD, S_TCMP, S_CHK, S_SCAN, S_FILL, S_FREE, S_RESP
  } state_e;

  state_e               state_q;
  logic                 cmd_q;
  logic [ID_W-1:0]      id_q;
  logic [LEN_W-1:0]     cnt_q;
  logic [TI_W-1:0]      idx_q;
  logic [TI_W-1:0]      slot_q;
  logic                 slot_ok_q;
  logic [TI_W-1:0]      hit_q;
  logic [BA_W-1:0]      start_q;
  logic [LEN_W-1:0]     len_q;
  logic [CNT_W-1:0]     b_q;
  logic                 pend_q;
  logic [BA_W-1:0]      pos_q;
  logic [CNT_W-1:0]     run_q;
  logic [BA_W-1:0]      rs_q;
  logic [BA_W-1:0]      a_q;
  logic [LEN_W-1:0]     rem_q;
  ffa_pkg::status_e     st_q;
  logic [FILES-1:0]     valid_q;
  logic                 m_valid_q;
  logic [23:0]          m_data_q;

  logic [ENT_W-1:0]     tbl_mem [FILES];
  logic [ENT_W-1:0]     tbl_rd_q;
  logic                 tbl_we;
  logic [ENT_W-1:0]     tbl_wdata;

  ffa_pkg::bm_cmd_t     bm_cmd;
  logic [BA_W-1:0]      bm_addr;
  logic                 bm_rd;

  logic [ID_W-1:0]      ent_id;
  logic [BA_W-1:0]      ent_start;
  logic [LEN_W-1:0]     ent_len;
  logic                 ent_hit;

  logic [CNT_W-1:0]     run_new;
  logic [BA_W-1:0]      rs_new;
  logic                 fit;
  logic                 bad_count;

  // table entry fields
  assign ent_len   = tbl_rd_q[LEN_W-1:0];
  assign ent_start = tbl_rd_q[BA_W+LEN_W-1:LEN_W];
  assign ent_id    = tbl_rd_q[ENT_W-1:BA_W+LEN_W];
  assign ent_hit   = valid_q[idx_q] && (ent_id == id_q);

  // free run tracking on the bit that returns from the bitmap
  always_comb begin
    run_new = run_q;
    rs_new  = rs_q;
    if (bm_rd) begin
      run_new = '0;
    end else begin
      if (run_q == '0) begin
        rs_new = pos_q;
      end
      run_new = run_q + CNT_W'(1);
    end
  end
  assign fit       = pend_q && !bm_rd && (CMP_W'(run_new) >= CMP_W'(cnt_q));
  assign bad_count = (cnt_q == '0) || (CMP_W'(cnt_q) > CMP_W'(BLOCKS));

  // bitmap port
  always_comb begin
    bm_cmd.wr_en  = (state_q == S_CLR) || (state_q == S_FILL) || (state_q == S_FREE);
    bm_cmd.wr_bit = (state_q == S_FILL);
    bm_addr       = (state_q == S_SCAN) ? b_q[BA_W-1:0] : a_q;
  end

  ffa_bitmap #(
    .BLOCKS (BLOCKS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .cmd_i  (bm_cmd),
    .addr_i (bm_addr),
    .rd_o   (bm_rd)
  );

  // file table: written on the last block of a fill, read at the walk index
  assign tbl_we    = (state_q == S_FILL) && (rem_q == LEN_W'(1));
  assign tbl_wdata = {id_q, start_q, cnt_q};

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[slot_q] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[idx_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cmd_q     <= ffa_pkg::CMD_ALLOC;
      id_q      <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      slot_q    <= '0;
      slot_ok_q <= 1'b0;
      hit_q     <= '0;
      start_q   <= '0;
      len_q     <= '0;
      b_q       <= '0;
      pend_q    <= 1'b0;
      pos_q     <= '0;
      run_q     <= '0;
      rs_q      <= '0;
      a_q       <= '0;
      rem_q     <= '0;
      st_q      <= ffa_pkg::ST_DONE;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // result slot drains independently, the response step refills it
      if (m_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        // clear the bitmap after reset
        S_CLR: begin
          a_q <= a_q + BA_W'(1);
          if (a_q == BA_W'(BLOCKS - 1)) begin
            state_q <= S_IDLE;
          end
        end

        // take a request
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q     <= s_axis_tuser;
            id_q      <= s_axis_tdata[ID_W-1:0];
            cnt_q     <= s_axis_tdata[ffa_pkg::FILE_ID_W +: LEN_W];
            idx_q     <= '0;
            slot_ok_q <= 1'b0;
            state_q   <= S_TRD;
          end
        end

        // table read in flight
        S_TRD: begin
          state_q <= S_TCMP;
        end

        // compare one table entry, note the first free slot
        S_TCMP: begin
          if (!valid_q[idx_q] && !slot_ok_q) begin
            slot_q    <= idx_q;
            slot_ok_q <= 1'b1;
          end
          if (ent_hit) begin
            if (cmd_q == ffa_pkg::CMD_RELEASE) begin
              hit_q   <= idx_q;
              start_q <= ent_start;
              len_q   <= ent_len;
              a_q     <= ent_start;
              rem_q   <= ent_len;
              state_q <= S_FREE;
            end else begin
              st_q    <= ffa_pkg::ST_EXISTS;
              state_q <= S_RESP;
            end
          end else if (idx_q == TI_W'(FILES - 1)) begin
            state_q <= S_CHK;
          end else begin
            idx_q   <= idx_q + TI_W'(1);
            state_q <= S_TRD;
          end
        end

        // table walk finished without a match
        S_CHK: begin
          priority if (cmd_q == ffa_pkg::CMD_RELEASE) begin
            st_q    <= ffa_pkg::ST_NOTFOUND;
            state_q <= S_RESP;
          end else if (!slot_ok_q) begin
            st_q    <= ffa_pkg::ST_FULL;
            state_q <= S_RESP;
          end else if (bad_count) begin
            st_q    <= ffa_pkg::ST_NOROOM;
            state_q <= S_RESP;
          end else begin
            b_q     <= '0;
            pend_q  <= 1'b0;
            run_q   <= '0;
            state_q <= S_SCAN;
          end
        end

        // bitmap scan, one block per cycle, registered read issued ahead of the check
        S_SCAN: begin
          if (b_q < CNT_W'(BLOCKS)) begin
            b_q    <= b_q + CNT_W'(1);
            pend_q <= 1'b1;
            pos_q  <= b_q[BA_W-1:0];
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            run_q <= run_new;
            rs_q  <= rs_new;
          end
          if (fit) begin
            start_q <= rs_new;
            len_q   <= cnt_q;
            a_q     <= rs_new;
            rem_q   <= cnt_q;
            state_q <= S_FILL;
          end else if (pend_q && (pos_q == BA_W'(BLOCKS - 1))) begin
            st_q    <= ffa_pkg::ST_NOROOM;
            state_q <= S_RESP;
          end
        end

        // mark the new extent used
        S_FILL: begin
          a_q   <= a_q + BA_W'(1);
          rem_q <= rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            valid_q[slot_q] <= 1'b1;
            st_q            <= ffa_pkg::ST_DONE;
            state_q         <= S_RESP;
          end
        end

        // free the released extent
        S_FREE: begin
          a_q   <= a_q + BA_W'(1);
          rem_q <= rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            valid_q[hit_q] <= 1'b0;
            st_q           <= ffa_pkg::ST_DONE;
            state_q        <= S_RESP;
          end
        end

        // hand the result over once the slot is free
        S_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (st_q == ffa_pkg::ST_DONE) begin
              m_data_q <= {4'b0, len_q, ffa_pkg::START_W'(start_q), st_q};
            end else begin
              m_data_q <= {4'b0, LEN_W'(0), ffa_pkg::START_W'(0), st_q};
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  `FFA_ASSERT(a_result_from_resp, $rose(m_valid_q) |-> $past(state_q == S_RESP),
              "result raised outside the response step")
  `FFA_ASSERT(a_fail_zero,
              (m_valid_q && (m_data_q[2:0] != ffa_pkg::ST_DONE)) |-> (m_data_q[19:3] == '0),
              "failed request carries a non-zero extent")
  `FFA_ASSERT_ALWAYS(a_no_req_in_clear, (state_q == S_CLR) |-> !s_axis_tready,
                     "request taken while the bitmap is being cleared")
  `FFA_ASSERT(a_fill_needs_slot, (state_q == S_FILL) |-> (slot_ok_q && !valid_q[slot_q]),
              "fill without a free table slot")

endmodule

/* test/first_fit_extent_allocator_core_tb.sv */
// self-checking testbench of the first-fit extent allocator core
module first_fit_extent_allocator_core_tb;

  localparam int unsigned BLOCKS       = ffa_pkg::BLOCKS_DEF;
  localparam int unsigned FILES        = ffa_pkg::FILES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned TAIL_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned HOLD_CYCLES  = 1500;

  typedef struct {
    logic             cmd;
    logic [15:0]      file_id;
    logic [8:0]       count;
    int unsigned      gap;
    bit               drain;
  } request_t;

  typedef struct packed {
    ffa_pkg::status_e status;
    logic [7:0]       start_block;
    logic [8:0]       length;
  } outcome_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // stimulus and expected outcomes
  request_t    request_q[$];
  outcome_t    outcome_q[$];
  request_t    cur_req;
  int          wait_left     = -1;
  int unsigned n_sent        = 0;
  int unsigned n_recv        = 0;
  int unsigned n_errors      = 0;
  int unsigned stall_left    = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  // predictor state: occupancy map and file table
  bit          map_used[BLOCKS];
  bit          tbl_valid[FILES];
  logic [15:0] tbl_id[FILES];
  int unsigned tbl_start[FILES];
  int unsigned tbl_len[FILES];

  first_fit_extent_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // outcome of one request, updating the occupancy map and file table
  function automatic outcome_t service_request(input request_t r);
    outcome_t res;
    int       hit;
    int       slot;
    int       pos;
    int       run;
    int       run_base;
    res = '{ffa_pkg::ST_DONE, 8'd0, 9'd0};
    hit = -1;
    slot = -1;
    pos = -1;
    run = 0;
    run_base = 0;
    for (int e = FILES - 1; e >= 0; e--) begin
      if (tbl_valid[e] && tbl_id[e] == r.file_id) hit = e;
      if (!tbl_valid[e]) slot = e;
    end
    if (r.cmd == ffa_pkg::CMD_RELEASE) begin
      if (hit < 0) begin
        res.status = ffa_pkg::ST_NOTFOUND;
      end else begin
        for (int b = tbl_start[hit]; b < tbl_start[hit] + tbl_len[hit] && b < BLOCKS; b++)
          map_used[b] = 1'b0;
        tbl_valid[hit] = 1'b0;
        res.start_block = 8'(tbl_start[hit]);
        res.length = 9'(tbl_len[hit]);
      end
      return res;
    end
    // allocate: duplicate id, then full table, then count and free space
    if (hit >= 0) begin
      res.status = ffa_pkg::ST_EXISTS;
      return res;
    end
    if (slot < 0) begin
      res.status = ffa_pkg::ST_FULL;
      return res;
    end
    if (r.count == 0 || r.count > BLOCKS) begin
      res.status = ffa_pkg::ST_NOROOM;
      return res;
    end
    for (int b = 0; b < BLOCKS && pos < 0; b++) begin
      if (map_used[b]) begin
        run = 0;
      end else begin
        if (run == 0) run_base = b;
        run++;
        if (run >= r.count) pos = run_base;
      end
    end
    if (pos < 0) begin
      res.status = ffa_pkg::ST_NOROOM;
      return res;
    end
    for (int b = pos; b < pos + r.count && b < BLOCKS; b++) map_used[b] = 1'b1;
    tbl_valid[slot] = 1'b1;
    tbl_id[slot] = r.file_id;
    tbl_start[slot] = pos;
    tbl_len[slot] = 32'(r.count);
    res.start_block = 8'(pos);
    res.length = r.count;
    return res;
  endfunction

  // idle cycles before a request, mostly short and now and then long
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // block count for an allocate, small ones favoured
  function automatic logic [8:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 9'($urandom_range(1, 24));
    if (roll < 90) return 9'($urandom_range(25, 128));
    if (roll < 95) return 9'($urandom_range(129, 256));
    if (roll < 97) return 9'd0;
    return 9'($urandom_range(257, 511));
  endfunction

  task automatic add_request(input logic cmd, input logic [15:0] file_id,
                             input logic [8:0] count, input int unsigned gap,
                             input bit drain);
    request_t r;
    r.cmd = cmd;
    r.file_id = file_id;
    r.count = count;
    r.gap = gap;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit          take;
    int unsigned sent_now;
    take = s_axis_tvalid && s_axis_tready;
    sent_now = n_sent + take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (take) begin
        outcome_q.push_back(service_request(cur_req));
        n_sent <= sent_now;
      end
      if (!s_axis_tvalid || take) begin
        if (request_q.size() > 0 && wait_left < 0) wait_left = request_q[0].gap;
        if (request_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (wait_left > 0) begin
          wait_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q[0].drain && sent_now != n_recv) begin
          // hold back until every outcome is in
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = request_q.pop_front();
          wait_left = -1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, cur_req.count, cur_req.file_id};
          s_axis_tuser  <= cur_req.cmd;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t    want;
    logic [2:0]  got_status;
    logic [7:0]  got_start;
    logic [8:0]  got_length;
    bit          rx_burst;
    got_status = m_axis_tdata[2:0];
    got_start  = m_axis_tdata[10:3];
    got_length = m_axis_tdata[19:11];
    rx_burst = ((n_recv / 80) % 3) == 1;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_recv <= n_recv + 1;
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result status %0d start %0d length %0d",
                   $time, got_status, got_start, got_length);
          n_errors++;
        end else begin
          want = outcome_q.pop_front();
          if (got_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
            n_errors++;
          end
          if (got_start !== want.start_block) begin
            $display("%0t: start_block expected %0d actual %0d",
                     $time, want.start_block, got_start);
            n_errors++;
          end
          if (got_length !== want.length) begin
            $display("%0t: length expected %0d actual %0d", $time, want.length, got_length);
            n_errors++;
          end
        end
        // long hold-off so the core backs up onto its request side
        if (n_recv == 150 || n_recv == 700) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!rx_burst && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap(1'b0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [15:0] id_pool[POOL_SIZE];
    int unsigned alloc_bias;
    int unsigned roll;
    bit          burst;
    for (int k = 0; k < POOL_SIZE - 2; k++) id_pool[k] = 16'($urandom_range(0, 65535));
    id_pool[POOL_SIZE-2] = 16'd4;
    id_pool[POOL_SIZE-1] = 16'd5;

    // whole store, then extremes of the count
    add_request(ffa_pkg::CMD_ALLOC, 16'hFFFF, 9'd256, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'h0000, 9'd1, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_RELEASE, 16'hFFFF, 9'd511, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'h0000, 9'd0, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'h0000, 9'd257, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_RELEASE, 16'h1234, 9'd0, pick_gap(1'b0), 1'b0);
    // fragments, duplicate id, and merging of neighbouring free runs
    add_request(ffa_pkg::CMD_ALLOC, 16'd1, 9'd10, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd2, 9'd20, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd3, 9'd5, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd1, 9'd7, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_RELEASE, 16'd2, 9'd0, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd4, 9'd21, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_RELEASE, 16'd1, 9'd0, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd5, 9'd30, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_RELEASE, 16'd3, 9'd0, pick_gap(1'b0), 1'b0);
    // fill the table, then full table and duplicate on a full table
    for (int k = 0; k < FILES - 2; k++)
      add_request(ffa_pkg::CMD_ALLOC, id_pool[k], 9'd1, 0, 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'h8000, 9'd1, pick_gap(1'b0), 1'b0);
    add_request(ffa_pkg::CMD_ALLOC, 16'd4, 9'd1, pick_gap(1'b0), 1'b0);

    // random traffic over a small id pool, alternating alloc-heavy and release-heavy
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = ((i / 60) % 4) == 1;
      alloc_bias = ((i / 50) % 2 == 0) ? 65 : 35;
      roll = $urandom_range(0, 99);
      if (roll < 5)
        add_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                    9'($urandom_range(0, 511)), pick_gap(burst), (i % 250) == 0);
      else if ($urandom_range(0, 99) < alloc_bias)
        add_request(ffa_pkg::CMD_ALLOC, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    pick_count(), pick_gap(burst), (i % 250) == 0);
      else
        add_request(ffa_pkg::CMD_RELEASE, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    9'($urandom_range(0, 511)), pick_gap(burst), (i % 250) == 0);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // look between edges so the driver and monitor updates have settled
    while (request_q.size() > 0 || s_axis_tvalid || n_recv != n_sent) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && outcome_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
